// ===== rtl/efg_pkg.sv =====
// Package: shared types and constants for the event flag group.
`timescale 1ns / 1ps
package efg_pkg;
    localparam int FLAG_BITS_DEF   = 32;
    localparam int MAX_WAITERS_DEF = 16;

    localparam logic [2:0] OP_SET    = 3'd0;
    localparam logic [2:0] OP_CLEAR  = 3'd1;
    localparam logic [2:0] OP_POLL   = 3'd2;
    localparam logic [2:0] OP_WAIT   = 3'd3;
    localparam logic [2:0] OP_CANCEL = 3'd4;
    localparam logic [2:0] OP_DELETE = 3'd5;
    localparam logic [2:0] OP_CREATE = 3'd6;
    localparam logic [2:0] OP_RSVD   = 3'd7;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_NOT_MET = 3'd1;
    localparam logic [2:0] ST_BAD_PAR = 3'd2;
    localparam logic [2:0] ST_NO_GRP  = 3'd3;
    localparam logic [2:0] ST_EXISTS  = 3'd4;
    localparam logic [2:0] ST_FULL    = 3'd5;

    typedef struct packed {
        logic [2:0]  operation;
        logic [31:0] pattern;
        logic        match_any;
        logic        clear_on_release;
        logic [3:0]  waiter_id;
    } req_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] flags_seen;
        logic [15:0] released_mask;
        logic        queued;
    } rsp_t;

    // Command broadcast to every cell of the chain.
    typedef struct packed {
        logic shift;   // take neighbor's entry this cycle
        logic kill;    // invalidate all cells
    } cell_ctl_t;
endpackage

// ===== rtl/efg_cell.sv =====
// Cell: one waiter slot, loads a new waiter or shifts from its upper neighbor to close gaps.
`timescale 1ns / 1ps
module efg_cell #(
    parameter int FLAG_BITS = efg_pkg::FLAG_BITS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  efg_pkg::cell_ctl_t   ctl,
    input  logic                 shift_en,
    input  logic                 load_en,
    input  logic                 nb_valid,
    input  logic [3:0]           nb_id,
    input  logic [FLAG_BITS-1:0] nb_pat,
    input  logic                 nb_any,
    input  logic                 nb_clr,
    input  logic [3:0]           ld_id,
    input  logic [FLAG_BITS-1:0] ld_pat,
    input  logic                 ld_any,
    input  logic                 ld_clr,
    output logic                 valid,
    output logic [3:0]           id,
    output logic [FLAG_BITS-1:0] pat,
    output logic                 any,
    output logic                 clr
);
    logic                 valid_reg;
    logic [3:0]           id_reg;
    logic [FLAG_BITS-1:0] pat_reg;
    logic                 any_reg;
    logic                 clr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (ctl.kill)
        begin
            valid_reg <= 1'b0;
        end
        else if (ctl.shift && shift_en)
        begin
            valid_reg <= nb_valid;
        end
        else if (load_en)
        begin
            valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.shift && shift_en)
        begin
            id_reg  <= nb_id;
            pat_reg <= nb_pat;
            any_reg <= nb_any;
            clr_reg <= nb_clr;
        end
        else if (load_en)
        begin
            id_reg  <= ld_id;
            pat_reg <= ld_pat;
            any_reg <= ld_any;
            clr_reg <= ld_clr;
        end
    end

    assign valid = valid_reg;
    assign id    = id_reg;
    assign pat   = pat_reg;
    assign any   = any_reg;
    assign clr   = clr_reg;
endmodule

// ===== rtl/event_flag_group_with_waiters_top.sv =====
// Top level: event flag group with an arrival-ordered chain of waiter cells.
// Set and cancel walk the chain one cell per cycle; other requests do not walk it.
// One request at a time: the next is taken once the result is out or leaving.
// Reset: rst_n asynchronous active low clears flags, group, valid bits, count.
`timescale 1ns / 1ps
module event_flag_group_with_waiters_top #(
    parameter int FLAG_BITS   = efg_pkg::FLAG_BITS_DEF,
    parameter int MAX_WAITERS = efg_pkg::MAX_WAITERS_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  efg_pkg::req_t in_data,
    output logic          out_valid,
    input  logic          out_ready,
    output efg_pkg::rsp_t out_data
);
    localparam int IW = (MAX_WAITERS > 1) ? $clog2(MAX_WAITERS) : 1;
    localparam int CW = $clog2(MAX_WAITERS + 1);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_EXEC = 4'b0010,
        S_WALK = 4'b0100,
        S_DONE = 4'b1000
    } state_t;

    state_t               state_reg, state_next;
    efg_pkg::req_t        req_reg;
    logic [FLAG_BITS-1:0] flags_reg, flags_next;
    logic                 exists_reg, exists_next;
    logic [CW-1:0]        count_reg, count_next;
    logic [CW-1:0]        ptr_reg, ptr_next;
    logic [IW-1:0]        ptr_idx;
    efg_pkg::rsp_t        rsp_reg, rsp_next;
    logic                 out_valid_reg, out_valid_next;

    // Cell chain wiring.
    logic                 c_valid [MAX_WAITERS];
    logic [3:0]           c_id    [MAX_WAITERS];
    logic [FLAG_BITS-1:0] c_pat   [MAX_WAITERS];
    logic                 c_any   [MAX_WAITERS];
    logic                 c_clr   [MAX_WAITERS];
    efg_pkg::cell_ctl_t   ctl;
    logic                 load_go;

    logic [FLAG_BITS-1:0] pat;
    logic                 zero_pat;
    logic                 cond_req;
    logic                 dup_id;
    logic                 cur_hit;
    logic [FLAG_BITS-1:0] cur_and;

    genvar g;
    generate
        for (g = 0; g < MAX_WAITERS; g++)
        begin : g_cell
            logic                 nv;
            logic [3:0]           nid;
            logic [FLAG_BITS-1:0] npat;
            logic                 nany, nclr;
            if (g == MAX_WAITERS - 1)
            begin : g_end
                assign nv = 1'b0; assign nid = '0; assign npat = '0;
                assign nany = 1'b0; assign nclr = 1'b0;
            end
            else
            begin : g_mid
                assign nv = c_valid[g+1]; assign nid = c_id[g+1];
                assign npat = c_pat[g+1]; assign nany = c_any[g+1];
                assign nclr = c_clr[g+1];
            end
            efg_cell #(.FLAG_BITS(FLAG_BITS)) u_cell (
                .clk(clk), .rst_n(rst_n), .ctl(ctl),
                .shift_en(CW'(g) >= ptr_reg),
                .load_en(load_go && (count_reg == CW'(g))),
                .nb_valid(nv), .nb_id(nid), .nb_pat(npat), .nb_any(nany),
                .nb_clr(nclr),
                .ld_id(req_reg.waiter_id), .ld_pat(pat),
                .ld_any(req_reg.match_any), .ld_clr(req_reg.clear_on_release),
                .valid(c_valid[g]), .id(c_id[g]), .pat(c_pat[g]),
                .any(c_any[g]), .clr(c_clr[g])
            );
        end
    endgenerate

    assign pat      = FLAG_BITS'(req_reg.pattern);
    assign zero_pat = (pat == '0);
    assign cond_req = req_reg.match_any ? ((flags_reg & pat) != '0)
                                        : ((flags_reg & pat) == pat);
    // The pointer runs one past the last cell to end the walk; index with the low bits.
    assign ptr_idx  = ptr_reg[IW-1:0];

    // Duplicate check over the chain: independent compares, OR-reduced.
    always_comb
    begin
        dup_id = 1'b0;
        for (int k = 0; k < MAX_WAITERS; k++)
        begin
            if (c_valid[k] && (c_id[k] == req_reg.waiter_id))
            begin
                dup_id = 1'b1;
            end
        end
    end

    // Condition of the cell under the walk pointer.
    assign cur_and = flags_reg & c_pat[ptr_idx];
    assign cur_hit = c_any[ptr_idx] ? (cur_and != '0) : (cur_and == c_pat[ptr_idx]);

    always_comb
    begin
        state_next     = state_reg;
        flags_next     = flags_reg;
        exists_next    = exists_reg;
        count_next     = count_reg;
        ptr_next       = ptr_reg;
        rsp_next       = rsp_reg;
        out_valid_next = out_valid_reg;
        ctl            = '0;
        load_go        = 1'b0;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid && in_ready)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                rsp_next   = '0;
                ptr_next   = '0;
                state_next = S_DONE;
                if (req_reg.operation == efg_pkg::OP_RSVD)
                begin
                    rsp_next.status = efg_pkg::ST_BAD_PAR;
                end
                else if (req_reg.operation == efg_pkg::OP_CREATE)
                begin
                    if (exists_reg)
                    begin
                        rsp_next.status = efg_pkg::ST_EXISTS;
                    end
                    else
                    begin
                        ctl.kill    = 1'b1;
                        count_next  = '0;
                        flags_next  = pat;
                        exists_next = 1'b1;
                    end
                    rsp_next.flags_seen = 32'(exists_reg ? flags_reg : pat);
                end
                else if (((req_reg.operation == efg_pkg::OP_SET)
                          || (req_reg.operation == efg_pkg::OP_POLL)
                          || (req_reg.operation == efg_pkg::OP_WAIT)) && zero_pat)
                begin
                    rsp_next.status = efg_pkg::ST_BAD_PAR;
                end
                else if (!exists_reg)
                begin
                    rsp_next.status = efg_pkg::ST_NO_GRP;
                end
                else
                begin
                    case (req_reg.operation)
                        efg_pkg::OP_SET:
                        begin
                            flags_next          = flags_reg | pat;
                            rsp_next.flags_seen = 32'(flags_reg | pat);
                            if (count_reg != '0)
                            begin
                                state_next = S_WALK;
                            end
                        end
                        efg_pkg::OP_CLEAR:
                        begin
                            flags_next          = flags_reg & pat;
                            rsp_next.flags_seen = 32'(flags_reg & pat);
                        end
                        efg_pkg::OP_POLL, efg_pkg::OP_WAIT:
                        begin
                            rsp_next.flags_seen = 32'(flags_reg);
                            if (cond_req)
                            begin
                                if (req_reg.clear_on_release)
                                begin
                                    flags_next = flags_reg & ~pat;
                                end
                            end
                            else if (req_reg.operation == efg_pkg::OP_POLL)
                            begin
                                rsp_next.status = efg_pkg::ST_NOT_MET;
                            end
                            else if (dup_id)
                            begin
                                rsp_next.status = efg_pkg::ST_BAD_PAR;
                            end
                            else if (count_reg >= CW'(MAX_WAITERS))
                            begin
                                rsp_next.status = efg_pkg::ST_FULL;
                            end
                            else
                            begin
                                load_go         = 1'b1;
                                count_next      = count_reg + 1'b1;
                                rsp_next.status = efg_pkg::ST_NOT_MET;
                                rsp_next.queued = 1'b1;
                            end
                        end
                        efg_pkg::OP_CANCEL:
                        begin
                            rsp_next.flags_seen = 32'(flags_reg);
                            rsp_next.status     = efg_pkg::ST_NOT_MET;
                            if (count_reg != '0)
                            begin
                                state_next = S_WALK;
                            end
                        end
                        efg_pkg::OP_DELETE:
                        begin
                            rsp_next.flags_seen = 32'(flags_reg);
                            for (int k = 0; k < MAX_WAITERS; k++)
                            begin
                                if (c_valid[k])
                                begin
                                    rsp_next.released_mask[c_id[k]] = 1'b1;
                                end
                            end
                            ctl.kill    = 1'b1;
                            count_next  = '0;
                            flags_next  = '0;
                            exists_next = 1'b0;
                        end
                        default:
                        begin
                            rsp_next.status = efg_pkg::ST_BAD_PAR;
                        end
                    endcase
                end
            end
            S_WALK:
            begin
                // Examine one cell per cycle; on removal shift the tail down.
                if (ptr_reg >= count_reg)
                begin
                    state_next = S_DONE;
                end
                else if (req_reg.operation == efg_pkg::OP_CANCEL)
                begin
                    if (c_id[ptr_idx] == req_reg.waiter_id)
                    begin
                        ctl.shift       = 1'b1;
                        count_next      = count_reg - 1'b1;
                        rsp_next.status = efg_pkg::ST_OK;
                        state_next      = S_DONE;
                    end
                    else
                    begin
                        ptr_next = ptr_reg + 1'b1;
                    end
                end
                else if (cur_hit)
                begin
                    ctl.shift  = 1'b1;
                    count_next = count_reg - 1'b1;
                    rsp_next.released_mask[c_id[ptr_idx]] = 1'b1;
                    if (c_clr[ptr_idx])
                    begin
                        flags_next = flags_reg & ~c_pat[ptr_idx];
                    end
                    if (flags_next == '0)
                    begin
                        state_next = S_DONE;
                    end
                end
                else
                begin
                    ptr_next = ptr_reg + 1'b1;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            flags_reg     <= '0;
            exists_reg    <= 1'b0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            flags_reg     <= flags_next;
            exists_reg    <= exists_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ptr_reg <= ptr_next;
        rsp_reg <= rsp_next;
        if (in_valid && in_ready)
        begin
            req_reg <= in_data;
        end
    end

    // Hold off a new request while busy and until the previous result leaves the output register.
    assign in_ready  = (state_reg == S_IDLE) && (!out_valid_reg || out_ready);
    assign out_valid = out_valid_reg;
    assign out_data  = rsp_reg;

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(MAX_WAITERS))
        else $error("waiter count exceeds table depth");
    a_no_group_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !exists_reg |-> (count_reg == '0))
        else $error("waiters present without a group");
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> !in_ready)
        else $error("request taken while busy");
    a_ptr_walk: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WALK) |-> (ptr_reg <= count_reg))
        else $error("walk pointer beyond chain");
`endif
endmodule
